// ===== src/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray-sphere intersection block
// Holds the fixed output format, the miss and saturation codes and the result flag record.
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int OUT_FRAC  = 16;
   localparam int OUT_WIDTH = 32;
   localparam logic [OUT_WIDTH-1:0] MISS_VALUE = 32'hFFFF_0000;
   localparam logic [OUT_WIDTH-1:0] SAT_POS    = 32'h7FFF_FFFF;
   localparam logic [OUT_WIDTH-1:0] SAT_NEG    = 32'h8000_0000;

   // Result flags that travel alongside every item.
   typedef struct packed {
      logic hit;
      logic degenerate;
   } flags_type;

endpackage

// ===== src/rsi_fifo.sv =====
// ----------------------------------------------------------------------------
// rsi_fifo: short queue between the front and the back
// A register-based FIFO with a fill count; full and empty flags come from it.
// ----------------------------------------------------------------------------
module rsi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign wr_ready = (cnt_ff != AW'(0) + (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wp_in  = do_wr ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = do_rd ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end
endmodule

// ===== src/rsi_front.sv =====
// ----------------------------------------------------------------------------
// rsi_front: quadratic coefficient pipeline
// Forms oc, a, b, c and the discriminant over registered stages and
// classifies each request as miss, degenerate or hit.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; #(
   parameter int CW = 16,
   parameter int AW = 2*CW+3,
   parameter int DW = 4*CW+8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [10*CW-1:0]     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [AW-1:0] out_a,
   output logic signed [AW-1:0] out_b,
   output logic signed [DW-1:0] out_disc,
   output flags_type            out_flags
);
   localparam int OW = CW+1;
   localparam int PW = 2*OW;

   logic               advance;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [OW-1:0] oc_ff [3];
   logic signed [CW-1:0] d_ff [3];
   logic signed [CW-1:0] r_ff;
   logic signed [AW-1:0] a2_ff, b2_ff, c2_ff;
   logic signed [AW-1:0] a3_ff, b3_ff;
   logic signed [DW-1:0] bb3_ff, ac3_ff;
   logic signed [AW-1:0] a4_ff, b4_ff;
   logic signed [DW-1:0] disc4_ff;

   // The whole pipe moves together; a stall holds every stage.
   assign advance  = !v4_ff || out_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            oc_ff[i] <= OW'($signed(in_data[i*CW +: CW]))
                      - OW'($signed(in_data[(6+i)*CW +: CW]));
            d_ff[i]  <= $signed(in_data[(3+i)*CW +: CW]);
         end
         r_ff <= $signed(in_data[9*CW +: CW]);
         // Stage 2: ten products and sums, each product under 34 bits.
         a2_ff <= AW'(PW'(d_ff[0])*PW'(d_ff[0])) + AW'(PW'(d_ff[1])*PW'(d_ff[1]))
                + AW'(PW'(d_ff[2])*PW'(d_ff[2]));
         b2_ff <= AW'(PW'(oc_ff[0])*PW'(d_ff[0])) + AW'(PW'(oc_ff[1])*PW'(d_ff[1]))
                + AW'(PW'(oc_ff[2])*PW'(d_ff[2]));
         c2_ff <= AW'(PW'(oc_ff[0])*PW'(oc_ff[0])) + AW'(PW'(oc_ff[1])*PW'(oc_ff[1]))
                + AW'(PW'(oc_ff[2])*PW'(oc_ff[2])) - AW'(PW'(r_ff)*PW'(r_ff));
         // Stage 3: b is doubled, so b*b = 4*b2*b2; the common 4 of b*b - 4ac is factored out and put back by a shift.
         a3_ff  <= a2_ff;
         b3_ff  <= AW'(b2_ff <<< 1);
         bb3_ff <= DW'(b2_ff) * DW'(b2_ff);
         ac3_ff <= DW'(a2_ff) * DW'(c2_ff);
         a4_ff    <= a3_ff;
         b4_ff    <= b3_ff;
         disc4_ff <= (bb3_ff - ac3_ff) <<< 2;
      end
   end

   assign out_valid            = v4_ff;
   assign out_a                = a4_ff;
   assign out_b                = b4_ff;
   assign out_disc             = disc4_ff;
   assign out_flags.hit        = !disc4_ff[DW-1];
   assign out_flags.degenerate = !disc4_ff[DW-1] && (a4_ff == '0);
endmodule

// ===== src/rsi_back.sv =====
// ----------------------------------------------------------------------------
// rsi_back: root and quotient pipeline
// Unrolled one-bit-per-stage square root then one-bit-per-stage division,
// with saturation to Q16.16 at the end.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; #(
   parameter int CW = 16,
   parameter int AW = 2*CW+3,
   parameter int DW = 4*CW+8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [AW-1:0]     in_a,
   input  logic signed [AW-1:0]     in_b,
   input  logic signed [DW-1:0]     in_disc,
   input  flags_type                in_flags,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [OUT_WIDTH-1:0]     out_t,
   output flags_type                out_flags
);
   localparam int SQ = DW/2;            // root bits
   localparam int NW = AW+1;            // |num| width
   localparam int QB = NW+OUT_FRAC;     // quotient bits
   localparam int RW = AW+2;            // division remainder width
   localparam int S  = SQ+QB+2;         // stages

   logic advance;
   logic               v_ff   [S];
   flags_type          f_ff   [S];
   logic signed [AW-1:0] a_ff [S-1];
   logic signed [AW-1:0] b_ff [SQ+1];
   logic [DW-1:0]      n_ff   [SQ];   // radicand, shifted out two bits a stage
   logic [SQ+1:0]      rem_ff [SQ+1];
   logic [SQ-1:0]      rt_ff  [SQ+1];
   logic [QB-1:0]      num_ff [SQ+1:S-1];
   logic               neg_ff [SQ+1:S-1];
   logic [RW-1:0]      dr_ff  [SQ+1:S-1];
   logic [QB-1:0]      q_ff   [SQ+1:S-1];
   logic [OUT_WIDTH-1:0] t_ff;
   flags_type          fo_ff;
   logic               vo_ff;

   assign advance  = !vo_ff || out_ready;
   assign in_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < S; k++) v_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < S; k++) v_ff[k] <= v_ff[k-1];
         vo_ff <= v_ff[S-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f_ff[0] <= in_flags; a_ff[0] <= in_a; b_ff[0] <= in_b;
         n_ff[0] <= in_disc; rem_ff[0] <= '0; rt_ff[0] <= '0;
         for (int k = 1; k < S; k++) f_ff[k] <= f_ff[k-1];
         for (int k = 1; k < S-1; k++) a_ff[k] <= a_ff[k-1];
         for (int k = 1; k <= SQ; k++) b_ff[k] <= b_ff[k-1];
         for (int k = 1; k < SQ; k++) n_ff[k] <= n_ff[k-1] << 2;
         // Square root stages: one result bit each.
         for (int k = 1; k <= SQ; k++) begin : sq
            logic [SQ+1:0] r2, tr;
            r2 = {rem_ff[k-1][SQ-1:0], n_ff[k-1][DW-1 -: 2]};
            tr = {rt_ff[k-1], 2'b01};
            if (r2 >= tr) begin
               rem_ff[k] <= r2 - tr;
               rt_ff[k]  <= {rt_ff[k-1][SQ-2:0], 1'b1};
            end else begin
               rem_ff[k] <= r2;
               rt_ff[k]  <= {rt_ff[k-1][SQ-2:0], 1'b0};
            end
         end
         // Numerator -b - root, magnitude scaled by 2^16.
         begin : mknum
            logic signed [NW:0] nm;
            nm = -(NW+1)'(b_ff[SQ]) - $signed({1'b0, (NW)'(rt_ff[SQ])});
            neg_ff[SQ+1] <= nm[NW];
            num_ff[SQ+1] <= {NW'(nm[NW] ? -nm : nm), OUT_FRAC'(0)};
            dr_ff[SQ+1]  <= '0;
            q_ff[SQ+1]   <= '0;
         end
         for (int k = SQ+2; k < S; k++) neg_ff[k] <= neg_ff[k-1];
         // Division stages: one quotient bit each, divisor 2a.
         for (int k = SQ+2; k < S; k++) begin : dv
            logic [RW-1:0] r1, dd;
            r1 = {dr_ff[k-1][RW-2:0], num_ff[k-1][QB-1]};
            dd = {1'b0, a_ff[k-1][AW-2:0], 1'b0};
            num_ff[k] <= num_ff[k-1] << 1;
            if (r1 >= dd) begin
               dr_ff[k] <= r1 - dd;
               q_ff[k]  <= {q_ff[k-1][QB-2:0], 1'b1};
            end else begin
               dr_ff[k] <= r1;
               q_ff[k]  <= {q_ff[k-1][QB-2:0], 1'b0};
            end
         end
         fo_ff <= f_ff[S-1];
         if (!f_ff[S-1].hit || f_ff[S-1].degenerate) t_ff <= MISS_VALUE;
         else if (neg_ff[S-1]) begin
            if (q_ff[S-1] >= QB'(SAT_NEG)) t_ff <= SAT_NEG;
            else t_ff <= OUT_WIDTH'(-q_ff[S-1]);
         end else begin
            if (q_ff[S-1] > QB'(SAT_POS)) t_ff <= SAT_POS;
            else t_ff <= q_ff[S-1][OUT_WIDTH-1:0];
         end
      end
   end

   assign out_valid = vo_ff;
   assign out_t     = t_ff;
   assign out_flags = fo_ff;
endmodule

// ===== src/ray_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect: streaming ray-sphere intersection test
// Requests pass through the front pipe, the queue and the back pipe in that order.
// Throughput: one request per cycle unless back-pressure stalls it; a stalled output
// holds the back pipe while the four-entry queue lets the front run on until it fills.
// Reset is synchronous and clears all valid bits; payload registers keep data.
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // origin_x,y,z, dir_x,y,z, center_x,y,z, sphere_radius (lowest first)
   input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // hit_distance[31:0], hit, degenerate, zero fill
   output logic [39:0]              rsp_tdata
);
   localparam int CW = COORD_WIDTH;
   localparam int AW = 2*CW+3;
   localparam int DW = 4*CW+8;
   localparam int QW = 2*AW+DW+2;

   logic                 fv, fr, qv, qr;
   logic signed [AW-1:0] fa, fb;
   logic signed [DW-1:0] fd;
   flags_type            ff, of;
   logic [QW-1:0]        qd;
   logic [OUT_WIDTH-1:0] t;

   rsi_front #(.CW(CW), .AW(AW), .DW(DW)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata[10*CW-1:0]), .out_valid(fv), .out_ready(fr),
      .out_a(fa), .out_b(fb), .out_disc(fd), .out_flags(ff));

   rsi_fifo #(.WIDTH(QW), .DEPTH(4)) u_fifo (
      .clock, .reset, .wr_valid(fv), .wr_ready(fr), .wr_data({fa, fb, fd, ff}),
      .rd_valid(qv), .rd_ready(qr), .rd_data(qd));

   rsi_back #(.CW(CW), .AW(AW), .DW(DW)) u_back (
      .clock, .reset, .in_valid(qv), .in_ready(qr),
      .in_a(qd[QW-1 -: AW]), .in_b(qd[QW-AW-1 -: AW]), .in_disc(qd[DW+1:2]),
      .in_flags(qd[1:0]), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_t(t), .out_flags(of));

   assign rsp_tdata = {6'b0, of.degenerate, of.hit, t};
endmodule

// ===== src/rsi_checker.sv =====
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks on the result channel
// Watches flag consistency, the miss value, result stability under back-pressure and valid after reset.
// ----------------------------------------------------------------------------
module rsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_degen_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[32]) else $error("degenerate without hit");
   a_miss_val: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[31:0] == 32'hFFFF0000)
      else $error("miss value wrong");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata);

// ===== test/ray_sphere_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// Ray-sphere intersection testbench
// Drives ray/sphere requests with random gaps, predicts each result with exact
// wide integer arithmetic and checks every response field in order.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb;
   import rsi_pkg::*;

   localparam int CW = 16;
   localparam int REQ_W = ((10*CW+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct {
      coord_type v[10];
   } ray_req_type;
   typedef struct {
      logic [OUT_WIDTH-1:0] hit_dist;
      logic hit;
      logic degenerate;
   } hit_result_type;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [39:0] rsp_tdata;

   ray_req_type pending_rays[$];
   hit_result_type expected_hits[$];
   int errors = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_armed = 0;
   bit drain_pause = 0;
   bit stim_done = 0;
   int tx_wait = 0, rx_wait = 0;
   int sent_count = 0;

   ray_sphere_intersect #(.COORD_WIDTH(CW)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic hit_result_type intersect_ray(ray_req_type r);
      logic signed [127:0] ocx, ocy, ocz, dx, dy, dz, rad, a, b, c, disc, num, q;
      logic [127:0] mag;
      logic [127:0] root, rem, trial;
      hit_result_type res;
      ocx = 128'(r.v[0]) - 128'(r.v[6]);
      ocy = 128'(r.v[1]) - 128'(r.v[7]);
      ocz = 128'(r.v[2]) - 128'(r.v[8]);
      dx = 128'(r.v[3]);
      dy = 128'(r.v[4]);
      dz = 128'(r.v[5]);
      rad = 128'(r.v[9]);
      a = dx*dx + dy*dy + dz*dz;
      b = 2 * (ocx*dx + ocy*dy + ocz*dz);
      c = ocx*ocx + ocy*ocy + ocz*ocz - rad*rad;
      disc = b*b - 4*a*c;
      res.hit_dist = MISS_VALUE;
      res.hit = 0;
      res.degenerate = 0;
      if (disc < 0) return res;
      res.hit = 1;
      if (a == 0) begin
         res.degenerate = 1;
         return res;
      end
      // Bitwise floor square root of the discriminant.
      root = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((disc >> (2*i)) & 3);
         trial = (root << 2) | 1;
         root = root << 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = root | 1;
         end
      end
      num = -b - $signed(root);
      mag = (num < 0) ? -num : num;
      q = $signed((mag << OUT_FRAC) / (2*a));
      if (num < 0)
         res.hit_dist = (q >= 128'sh8000_0000) ? SAT_NEG : OUT_WIDTH'(-q);
      else
         res.hit_dist = (q > 128'sh7FFF_FFFF) ? SAT_POS : OUT_WIDTH'(q);
      return res;
   endfunction

   function automatic logic [REQ_W-1:0] pack_ray(ray_req_type r);
      logic [REQ_W-1:0] d;
      d = '0;
      for (int i = 0; i < 10; i++) d[i*CW +: CW] = r.v[i];
      return d;
   endfunction

   function automatic ray_req_type random_ray();
      ray_req_type r;
      int mode;
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 10; i++) begin
         if (mode == 0) r.v[i] = coord_type'($urandom());
         else r.v[i] = coord_type'($signed($urandom_range(0, 2048)) - 1024);
      end
      // Aim roughly toward the sphere so that hits are common.
      if (mode == 2) begin
         for (int i = 0; i < 3; i++) r.v[3+i] = r.v[6+i] - r.v[i];
      end
      if (mode == 3 && $urandom_range(0, 7) == 0) begin
         r.v[3] = 0; r.v[4] = 0; r.v[5] = 0;
      end
      return r;
   endfunction

   function automatic ray_req_type fixed_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                             int cx, int cy, int cz, int rad);
      ray_req_type r;
      r.v[0] = coord_type'(ox); r.v[1] = coord_type'(oy); r.v[2] = coord_type'(oz);
      r.v[3] = coord_type'(dx); r.v[4] = coord_type'(dy); r.v[5] = coord_type'(dz);
      r.v[6] = coord_type'(cx); r.v[7] = coord_type'(cy); r.v[8] = coord_type'(cz);
      r.v[9] = coord_type'(rad);
      return r;
   endfunction

   initial begin
      ray_req_type r;
      // Plain hit, miss, zero direction, negative radius.
      pending_rays.push_back(fixed_ray(0, 0, 0, 256, 0, 0, 1280, 0, 0, 256));
      pending_rays.push_back(fixed_ray(0, 0, 0, 256, 0, 0, 1280, 2560, 0, 256));
      pending_rays.push_back(fixed_ray(0, 0, 0, 0, 0, 0, 1280, 0, 0, 256));
      pending_rays.push_back(fixed_ray(0, 0, 0, 256, 0, 0, 1280, 0, 0, -256));
      // Origin inside the sphere gives a negative root.
      pending_rays.push_back(fixed_ray(0, 0, 0, 256, 0, 0, 0, 0, 0, 512));
      // Tiny direction, huge sphere: a zero result and negative saturation.
      pending_rays.push_back(fixed_ray(0, 0, 0, 1, 0, 0, 32767, 0, 0, 32767));
      pending_rays.push_back(fixed_ray(0, 0, 0, 1, 0, 0, -32768, 0, 0, -32768));
      pending_rays.push_back(fixed_ray(0, 0, 0, -1, 0, 0, 32767, 0, 0, 32767));
      // Field extremes.
      pending_rays.push_back(fixed_ray(-32768, -32768, -32768, -32768, -32768, -32768,
                                       32767, 32767, 32767, -32768));
      pending_rays.push_back(fixed_ray(32767, 32767, 32767, 32767, 32767, 32767,
                                       -32768, -32768, -32768, 32767));
      pending_rays.push_back(fixed_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      pending_rays.push_back(fixed_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_rays.push_back(fixed_ray(32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0));
      // Tangent ray: discriminant exactly zero.
      pending_rays.push_back(fixed_ray(0, 256, 0, 256, 0, 0, 1280, 0, 0, 256));
      for (int i = 0; i < 1600; i++) begin
         r = random_ray();
         pending_rays.push_back(r);
      end
   end

   initial begin
      reset = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
   end

   // Driver. The accepted request leaves the queue first, so the next one is
   // always at the head.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         tx_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_hits.push_back(intersect_ray(pending_rays.pop_front()));
            sent_count <= sent_count + 1;
            if (sent_count == 800) drain_pause <= 1;
         end
         if (drain_pause && !(req_tvalid && req_tready) && expected_hits.size() == 0)
            drain_pause <= 0;
         if (req_tvalid && !req_tready) begin
            // Hold the current request.
         end else if (pending_rays.size() == 0
                      || drain_pause || (req_tvalid && req_tready && sent_count == 800)) begin
            req_tvalid <= 0;
            if (pending_rays.size() == 0)
               stim_done <= 1;
         end else if (tx_wait > 0 && !(sent_count > 300 && sent_count < 500)) begin
            req_tvalid <= 0;
            tx_wait <= tx_wait - 1;
         end else begin
            req_tvalid <= 1;
            req_tdata <= pack_ray(pending_rays[0]);
            tx_wait <= $urandom_range(0, 10);
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      hit_result_type exp_r;
      if (reset) begin
         rsp_tready <= 0;
         rx_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               errors++;
            end else begin
               exp_r = expected_hits.pop_front();
               if (rsp_tdata[31:0] !== exp_r.hit_dist) begin
                  $error("hit_distance expected %h actual %h", exp_r.hit_dist,
                         rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[32] !== exp_r.hit) begin
                  $error("hit expected %b actual %b", exp_r.hit, rsp_tdata[32]);
                  errors++;
               end
               if (rsp_tdata[33] !== exp_r.degenerate) begin
                  $error("degenerate expected %b actual %b", exp_r.degenerate,
                         rsp_tdata[33]);
                  errors++;
               end
            end
         end
         // One long hold-off while the driver offers requests without gaps.
         if (!hold_armed && sent_count >= 320) begin
            hold_armed <= 1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 0;
         end else if (sent_count > 1000 && sent_count < 1200) begin
            rsp_tready <= 1;
         end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
            if (rsp_tvalid && rsp_tready) rx_wait <= $urandom_range(0, 10);
         end
      end
   end

   // Watchdog and end of run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_hits.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_hits.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
